### src/wtsp_pkg.sv
// Shared constants, types and helpers for the world-to-screen projection pipeline.
// Used by every design module under src except wtsp_checker; depends on nothing else.
package wtsp_pkg;

    // Matrix store layout: view words first, projection words second.
    localparam int MATRIX_WORDS = 32;
    localparam int IDX_W        = $clog2(MATRIX_WORDS);
    localparam int HALF_WORDS   = MATRIX_WORDS / 2;

    // Item modes.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CAMERA_X      = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y      = 3'd1;
    localparam logic [2:0] CFG_CAMERA_Z      = 3'd2;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd4;

    // Near limit on w: 0.1 in single precision, at Q.32.
    localparam logic signed [63:0] W_MIN = 64'sd429496736;

    // Divider: quotient bits below the sign, and remainder width.
    localparam int QB = 31;
    localparam int RW = 96;

    // Control that travels with each word through the matrix stages.
    typedef struct packed {
        logic             vld;
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic [31:0]      val;
    } t_item_ctrl;

    // Saturate a wide signed value to signed 64 bits.
    function automatic logic signed [63:0] sat64(input logic signed [99:0] a);
        logic signed [63:0] res;
        if ((&a[99:63]) || !(|a[99:63])) begin
            res = a[63:0];
        end else if (a[99]) begin
            res = {1'b1, 63'b0};
        end else begin
            res = {1'b0, {63{1'b1}}};
        end
        return res;
    endfunction

endpackage

### src/wtsp_view.sv
// View transform stages: holds the view matrix and forms clip = V * (d, 1).
// Depends on wtsp_pkg.
module wtsp_view (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  wtsp_pkg::t_item_ctrl   i_ctrl,
    input  logic signed [48:0]     i_d [3],
    output wtsp_pkg::t_item_ctrl   o_ctrl,
    output logic signed [63:0]     o_clip [4]
);

    logic signed [31:0] r_vmat [wtsp_pkg::HALF_WORDS];

    wtsp_pkg::t_item_ctrl r1_ctrl, r2_ctrl, r3_ctrl;
    logic signed [56:0]   r1_pl [4][3];
    logic signed [56:0]   r1_ph [4][3];
    logic signed [31:0]   r1_vt [4];
    logic signed [58:0]   r2_hs [4];
    logic signed [59:0]   r2_ls [4];
    logic signed [63:0]   r3_clip [4];
    logic signed [63:0]   n_clip [4];
    logic signed [83:0]   n_tot [4];
    logic signed [67:0]   n_shr [4];

    // A view word is written as its item enters the first view stage.
    always_ff @(posedge i_clk) begin
        if (i_en && i_ctrl.vld && i_ctrl.mode == wtsp_pkg::MODE_WRITE
                && !i_ctrl.idx[wtsp_pkg::IDX_W-1]) begin
            r_vmat[i_ctrl.idx[wtsp_pkg::IDX_W-2:0]] <= i_ctrl.val;
        end
    end

    // Control travels with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl.vld <= 1'b0;
            r2_ctrl.vld <= 1'b0;
            r3_ctrl.vld <= 1'b0;
        end else if (i_en) begin
            r1_ctrl.vld <= i_ctrl.vld;
            r2_ctrl.vld <= r1_ctrl.vld;
            r3_ctrl.vld <= r2_ctrl.vld;
        end
        if (i_en) begin
            r1_ctrl.mode <= i_ctrl.mode;
            r1_ctrl.idx  <= i_ctrl.idx;
            r1_ctrl.val  <= i_ctrl.val;
            r2_ctrl.mode <= r1_ctrl.mode;
            r2_ctrl.idx  <= r1_ctrl.idx;
            r2_ctrl.val  <= r1_ctrl.val;
            r3_ctrl.mode <= r2_ctrl.mode;
            r3_ctrl.idx  <= r2_ctrl.idx;
            r3_ctrl.val  <= r2_ctrl.val;
        end
    end

    // Stage 1: partial products, delta split into a high 25-bit and a low 24-bit part.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_pl[r][c] <= $signed({1'b0, i_d[c][23:0]})
                                   * r_vmat[4'(r + 4 * c)];
                    r1_ph[r][c] <= $signed(i_d[c][48:24]) * r_vmat[4'(r + 4 * c)];
                end
                r1_vt[r] <= r_vmat[4'(12 + r)];
            end
        end
    end

    // Stage 2: row sums of high and low products, translation added to the low sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r2_hs[r] <= 59'(r1_ph[r][0]) + 59'(r1_ph[r][1]) + 59'(r1_ph[r][2]);
                r2_ls[r] <= 60'(r1_pl[r][0]) + 60'(r1_pl[r][1]) + 60'(r1_pl[r][2])
                            + (60'(r1_vt[r]) <<< 16);
            end
        end
    end

    // Stage 3: join the halves, drop 16 fraction bits with floor, saturate.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_tot[r]  = (84'(r2_hs[r]) <<< 24) + 84'(r2_ls[r]);
            n_shr[r]  = 68'(n_tot[r] >>> 16);
            n_clip[r] = wtsp_pkg::sat64(100'(n_shr[r]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_clip <= n_clip;
        end
    end

    assign o_ctrl = r3_ctrl;
    assign o_clip = r3_clip;

endmodule

### src/wtsp_proj.sv
// Projection stages: holds the projection matrix and forms ndc = P * clip.
// Depends on wtsp_pkg.
module wtsp_proj (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  wtsp_pkg::t_item_ctrl   i_ctrl,
    input  logic signed [63:0]     i_clip [4],
    output logic                   o_vld,
    output logic signed [63:0]     o_ndc [4]
);

    logic signed [31:0] r_pmat [wtsp_pkg::HALF_WORDS];

    logic               r1_vld, r2_vld, r3_vld;
    logic signed [64:0] r1_pl [4][4];
    logic signed [63:0] r1_ph [4][4];
    logic signed [65:0] r2_hs [4];
    logic signed [66:0] r2_ls [4];
    logic signed [63:0] r3_ndc [4];
    logic signed [98:0] n_tot [4];
    logic signed [63:0] n_ndc [4];

    // A projection word is written as its item leaves the view stages.
    always_ff @(posedge i_clk) begin
        if (i_en && i_ctrl.vld && i_ctrl.mode == wtsp_pkg::MODE_WRITE
                && i_ctrl.idx[wtsp_pkg::IDX_W-1]) begin
            r_pmat[i_ctrl.idx[wtsp_pkg::IDX_W-2:0]] <= i_ctrl.val;
        end
    end

    // Only point words go on from here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_ctrl.vld && i_ctrl.mode == wtsp_pkg::MODE_POINT;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Stage 1: partial products, clip split into 32-bit halves.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r1_pl[r][c] <= $signed({1'b0, i_clip[c][31:0]})
                                   * r_pmat[4'(r + 4 * c)];
                    r1_ph[r][c] <= $signed(i_clip[c][63:32]) * r_pmat[4'(r + 4 * c)];
                end
            end
        end
    end

    // Stage 2: row sums of each half.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r2_hs[r] <= 66'(r1_ph[r][0]) + 66'(r1_ph[r][1])
                            + 66'(r1_ph[r][2]) + 66'(r1_ph[r][3]);
                r2_ls[r] <= 67'(r1_pl[r][0]) + 67'(r1_pl[r][1])
                            + 67'(r1_pl[r][2]) + 67'(r1_pl[r][3]);
            end
        end
    end

    // Stage 3: join the halves and saturate to Q32.32.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_tot[r] = (99'(r2_hs[r]) <<< 32) + 99'(r2_ls[r]);
            n_ndc[r] = wtsp_pkg::sat64(100'(n_tot[r]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ndc <= n_ndc;
        end
    end

    assign o_vld = r3_vld;
    assign o_ndc = r3_ndc;

endmodule

### src/wtsp_screen.sv
// Viewport stages: near test, scaled numerators and the divisor 2w.
// Depends on wtsp_pkg.
module wtsp_screen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [63:0] i_ndc [4],
    input  logic [13:0]        i_screen_width,
    input  logic [13:0]        i_screen_height,
    output logic               o_vld,
    output logic               o_vis,
    output logic [88:0]        o_ux,
    output logic [88:0]        o_uy,
    output logic               o_negx,
    output logic               o_negy,
    output logic [64:0]        o_d
);

    logic               r1_vld, r2_vld, r3_vld;
    logic               r1_vis, r2_vis, r3_vis;
    logic signed [63:0] r1_w, r2_w;
    logic signed [64:0] r1_sx, r1_sy;
    logic signed [55:0] r2_lx, r2_hx, r2_ly, r2_hy;
    logic [88:0]        r3_ux, r3_uy;
    logic               r3_negx, r3_negy;
    logic [64:0]        r3_d;
    logic [21:0]        n_sw, n_sh;
    logic signed [89:0] n_nx, n_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Stage 1: near test and the factors that multiply each extent.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_vis <= i_ndc[3] >= wtsp_pkg::W_MIN;
            r1_w   <= i_ndc[3];
            r1_sx  <= 65'(i_ndc[0]) + 65'(i_ndc[3]);
            r1_sy  <= 65'(i_ndc[3]) - 65'(i_ndc[1]);
        end
    end

    // Stage 2: multiply by the extent in Q.8, factor split in a low 32-bit and a high 33-bit part.
    assign n_sw = {i_screen_width, 8'b0};
    assign n_sh = {i_screen_height, 8'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_vis <= r1_vis;
            r2_w   <= r1_w;
            r2_lx  <= $signed({1'b0, r1_sx[31:0]}) * $signed({1'b0, n_sw});
            r2_hx  <= $signed(r1_sx[64:32]) * $signed({1'b0, n_sw});
            r2_ly  <= $signed({1'b0, r1_sy[31:0]}) * $signed({1'b0, n_sh});
            r2_hy  <= $signed(r1_sy[64:32]) * $signed({1'b0, n_sh});
        end
    end

    // Stage 3: add w for rounding; a negative numerator is complemented so
    // that the divider sees a magnitude and floor division still holds.
    assign n_nx = (90'(r2_hx) <<< 32) + 90'(r2_lx) + 90'(r2_w);
    assign n_ny = (90'(r2_hy) <<< 32) + 90'(r2_ly) + 90'(r2_w);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_vis  <= r2_vis;
            r3_negx <= n_nx[89];
            r3_negy <= n_ny[89];
            r3_ux   <= n_nx[89] ? ~n_nx[88:0] : n_nx[88:0];
            r3_uy   <= n_ny[89] ? ~n_ny[88:0] : n_ny[88:0];
            r3_d    <= {r2_w[63:0], 1'b0};
        end
    end

    assign o_vld  = r3_vld;
    assign o_vis  = r3_vis;
    assign o_ux   = r3_ux;
    assign o_uy   = r3_uy;
    assign o_negx = r3_negx;
    assign o_negy = r3_negy;
    assign o_d    = r3_d;

endmodule

### src/wtsp_div.sv
// Pipelined restoring divider for both screen coordinates, one quotient bit
// per stage, with saturation to signed 32 bits. Depends on wtsp_pkg.
module wtsp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic        i_vis,
    input  logic [88:0] i_ux,
    input  logic [88:0] i_uy,
    input  logic        i_negx,
    input  logic        i_negy,
    input  logic [64:0] i_d,
    output logic        o_vld,
    output logic        o_vis,
    output logic [31:0] o_x,
    output logic [31:0] o_y
);

    localparam int QB = wtsp_pkg::QB;
    localparam int RW = wtsp_pkg::RW;

    logic [QB:0]    r_vld;
    logic [QB:0]    r_vis, r_ovx, r_ovy, r_negx, r_negy;
    logic [64:0]    r_d    [QB+1];
    logic [RW-1:0]  r_remx [QB+1];
    logic [RW-1:0]  r_remy [QB+1];
    logic [QB-1:0]  r_qx   [QB+1];
    logic [QB-1:0]  r_qy   [QB+1];
    logic [RW-1:0]  n_dsh  [QB+1];
    logic [RW-1:0]  n_remx [QB+1];
    logic [RW-1:0]  n_remy [QB+1];
    logic [QB-1:0]  n_qx   [QB+1];
    logic [QB-1:0]  n_qy   [QB+1];
    logic [RW-1:0]  n_dtop;
    logic [QB-1:0]  n_qcx, n_qcy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QB-1:0], i_vld};
        end
    end

    // Entry check: a quotient of 2^31 or more saturates.
    assign n_dtop = {i_d, {QB{1'b0}}};

    // Each stage tries the divisor shifted to its quotient bit.
    always_comb begin
        n_dsh[0]  = '0;
        n_remx[0] = '0;
        n_remy[0] = '0;
        n_qx[0]   = '0;
        n_qy[0]   = '0;
        for (int j = 1; j <= QB; j++) begin
            n_dsh[j]  = {r_d[j-1], {QB{1'b0}}} >> j;
            n_remx[j] = r_remx[j-1];
            n_remy[j] = r_remy[j-1];
            n_qx[j]   = r_qx[j-1];
            n_qy[j]   = r_qy[j-1];
            if (r_remx[j-1] >= n_dsh[j]) begin
                n_remx[j]      = r_remx[j-1] - n_dsh[j];
                n_qx[j][QB-j]  = 1'b1;
            end
            if (r_remy[j-1] >= n_dsh[j]) begin
                n_remy[j]      = r_remy[j-1] - n_dsh[j];
                n_qy[j][QB-j]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vis[0]  <= i_vis;
            r_negx[0] <= i_negx;
            r_negy[0] <= i_negy;
            r_ovx[0]  <= RW'(i_ux) >= n_dtop;
            r_ovy[0]  <= RW'(i_uy) >= n_dtop;
            r_d[0]    <= i_d;
            r_remx[0] <= RW'(i_ux);
            r_remy[0] <= RW'(i_uy);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            for (int j = 1; j <= QB; j++) begin
                r_vis[j]  <= r_vis[j-1];
                r_negx[j] <= r_negx[j-1];
                r_negy[j] <= r_negy[j-1];
                r_ovx[j]  <= r_ovx[j-1];
                r_ovy[j]  <= r_ovy[j-1];
                r_d[j]    <= r_d[j-1];
                r_remx[j] <= n_remx[j];
                r_remy[j] <= n_remy[j];
                r_qx[j]   <= n_qx[j];
                r_qy[j]   <= n_qy[j];
            end
        end
    end

    // Clamp, then undo the complement taken for negative numerators.
    assign n_qcx = r_ovx[QB] ? {QB{1'b1}} : r_qx[QB];
    assign n_qcy = r_ovy[QB] ? {QB{1'b1}} : r_qy[QB];

    assign o_vld = r_vld[QB];
    assign o_vis = r_vis[QB];
    assign o_x   = r_negx[QB] ? ~{1'b0, n_qcx} : {1'b0, n_qcx};
    assign o_y   = r_negy[QB] ? ~{1'b0, n_qcy} : {1'b0, n_qcy};

endmodule

### src/world_to_screen_projection.sv
// Top level of the world-to-screen projection: config registers, input stage,
// output register and the pipeline built from wtsp_view, wtsp_proj, wtsp_screen, wtsp_div.
// Depends on wtsp_pkg.
//
// The block takes one word per clock while o_stall is low and presents one result per
// point word after the word has passed 43 register stages: the input stage loaded at
// the accepting edge, three view stages, three projection stages, three viewport
// stages, 32 divider stages (an entry stage and one per quotient bit) and the output
// register. Matrix-write words flow down the same pipeline and update the view words
// as they enter the first view stage and the projection words after the view stages,
// so writes and points keep their order without draining. A stall on the output holds
// the whole pipeline; the input stall follows only the output register.
module world_to_screen_projection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [4:0]         i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [47:0] i_point_x,
    input  logic signed [47:0] i_point_y,
    input  logic signed [47:0] i_point_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_visible,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    logic signed [47:0]   r_cam_x, r_cam_y, r_cam_z;
    logic [13:0]          r_screen_width, r_screen_height;
    logic                 n_en;
    wtsp_pkg::t_item_ctrl r0_ctrl;
    logic signed [48:0]   r0_d [3];
    wtsp_pkg::t_item_ctrl v_ctrl;
    logic signed [63:0]   v_clip [4];
    logic                 p_vld;
    logic signed [63:0]   p_ndc [4];
    logic                 s_vld, s_vis, s_negx, s_negy;
    logic [88:0]          s_ux, s_uy;
    logic [64:0]          s_d;
    logic                 q_vld, q_vis;
    logic [31:0]          q_x, q_y;
    logic                 r_out_vld, r_out_vis;
    logic signed [31:0]   r_out_x, r_out_y;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x         <= '0;
            r_cam_y         <= '0;
            r_cam_z         <= '0;
            r_screen_width  <= 14'd1920;
            r_screen_height <= 14'd1080;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wtsp_pkg::CFG_CAMERA_X:      r_cam_x <= i_cfg_data;
                wtsp_pkg::CFG_CAMERA_Y:      r_cam_y <= i_cfg_data;
                wtsp_pkg::CFG_CAMERA_Z:      r_cam_z <= i_cfg_data;
                wtsp_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[13:0];
                wtsp_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign n_en    = !r_out_vld || !i_stall;
    assign o_stall = !n_en;

    // Input stage: latch the word and subtract the camera position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctrl.vld <= 1'b0;
        end else if (n_en) begin
            r0_ctrl.vld <= i_valid;
        end
        if (n_en) begin
            r0_ctrl.mode <= i_mode;
            r0_ctrl.idx  <= i_entry_index;
            r0_ctrl.val  <= i_entry_value;
            r0_d[0]      <= 49'(i_point_x) - 49'(r_cam_x);
            r0_d[1]      <= 49'(i_point_y) - 49'(r_cam_y);
            r0_d[2]      <= 49'(i_point_z) - 49'(r_cam_z);
        end
    end

    wtsp_view u_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctrl  (r0_ctrl),
        .i_d     (r0_d),
        .o_ctrl  (v_ctrl),
        .o_clip  (v_clip)
    );

    wtsp_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctrl  (v_ctrl),
        .i_clip  (v_clip),
        .o_vld   (p_vld),
        .o_ndc   (p_ndc)
    );

    wtsp_screen u_screen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (n_en),
        .i_vld           (p_vld),
        .i_ndc           (p_ndc),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_vld           (s_vld),
        .o_vis           (s_vis),
        .o_ux            (s_ux),
        .o_uy            (s_uy),
        .o_negx          (s_negx),
        .o_negy          (s_negy),
        .o_d             (s_d)
    );

    wtsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_vld   (s_vld),
        .i_vis   (s_vis),
        .i_ux    (s_ux),
        .i_uy    (s_uy),
        .i_negx  (s_negx),
        .i_negy  (s_negy),
        .i_d     (s_d),
        .o_vld   (q_vld),
        .o_vis   (q_vis),
        .o_x     (q_x),
        .o_y     (q_y)
    );

    // Output register; points behind the near limit report zero coordinates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_en) begin
            r_out_vld <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out_vis <= q_vis;
            r_out_x   <= q_vis ? q_x : '0;
            r_out_y   <= q_vis ? q_y : '0;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_visible  = r_out_vis;
    assign o_screen_x = r_out_x;
    assign o_screen_y = r_out_y;

endmodule

### src/wtsp_checker.sv
// Port-level checks for world_to_screen_projection, bound to the top level.
// Depends only on the top level's ports.
module wtsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_visible,
    input logic signed [31:0] o_screen_x,
    input logic signed [31:0] o_screen_y
);

    // Input backpressure comes only from a held result word.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not match output hold");

    // A point behind the near limit reports the origin.
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_screen_x == 0 && o_screen_y == 0))
        else $error("hidden point with nonzero coordinates");

    // Nothing leaves right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word right after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_screen_x)
                                  && $stable(o_screen_y) && $stable(o_visible)))
        else $error("stalled result word changed");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_visible  (o_visible),
    .o_screen_x (o_screen_x),
    .o_screen_y (o_screen_y)
);
